// File: design/pcbd_pkg.sv
// package for the per-class bounded deque
// request and response payload types, status and operation codes, controller interface
// no dependencies
package pcbd_pkg;

   // fixed field widths
   localparam int CLASS_IN_W = 5;
   localparam int TAG_IN_W   = 16;
   localparam int CAP_W      = 4;
   localparam int STATUS_W   = 2;

   // capacity limit after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

   // operation codes
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TAKE = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // request payload
   typedef struct packed {
      logic                  func;
      logic [CLASS_IN_W-1:0] class_index;
      logic                  urgent;
      logic [TAG_IN_W-1:0]   item_tag;
   } req_type;

   // response payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_IN_W-1:0] taken_tag;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;      // latch request, read class pointers
      logic commit;       // update class, write or read slot
      logic finish_take;  // return the slot just read
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_take;
      logic blocked;      // add on a full class or take on an empty one
   } dp_sts_type;

endpackage

// File: design/pcbd_ctrl.sv
// controller state machine for the per-class bounded deque
// sequences capture, commit and slot readout of one request at a time
// depends on pcbd_pkg
module pcbd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pcbd_pkg::dp_sts_type sts,
   output pcbd_pkg::dp_cmd_type cmd
);
   import pcbd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_META = 2'd1;
   localparam logic [1:0] S_SLOT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_META;
            end
         end
         S_META: begin
            cmd.commit = 1'b1;
            if (sts.is_take && !sts.blocked) begin
               state_in = S_SLOT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SLOT: begin
            cmd.finish_take = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // a slot readout only follows a commit
   a_slot_after_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_take |-> $past(cmd.commit))
      else $error("slot readout without preceding commit");

   // a capture is always followed by a commit
   a_commit_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.commit)
      else $error("capture not followed by commit");

   // at most one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("overlapping datapath commands");

endmodule

// File: design/pcbd_datapath.sv
// datapath for the per-class bounded deque
// class pointer memory with valid bits, slot memory, limit check, response register
// depends on pcbd_pkg
module pcbd_datapath #(
   parameter int CLASSES  = 32,
   parameter int SLOTS    = 8,
   parameter int TAG_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pcbd_pkg::req_type                    req_data,
   input  pcbd_pkg::dp_cmd_type                 cmd,
   output pcbd_pkg::dp_sts_type                 sts,
   input  logic                                 csr_we,
   input  logic [pcbd_pkg::CAP_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   output pcbd_pkg::rsp_type                    rsp_data
);
   import pcbd_pkg::*;

   localparam int CLS_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int META_W = SLOT_W + CNT_W;

   // storage
   logic [TAG_BITS-1:0] slot_mem [CLASSES][SLOTS];
   logic [META_W-1:0]   meta_mem [CLASSES];
   logic [CLASSES-1:0]  class_valid_ff;

   logic [CAP_W-1:0]    cap_ff;
   req_type             req_ff;
   logic [CLS_W-1:0]    cls_ff;
   logic [META_W-1:0]   meta_rd_ff;
   logic                meta_ok_ff;
   logic [TAG_BITS-1:0] slot_rd_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic [CLS_W-1:0]    cls_sel;
   logic [SLOT_W-1:0]   head;
   logic [CNT_W-1:0]    cnt;
   logic [LIM_W-1:0]    limit;
   logic                full;
   logic                empty;
   logic [SLOT_W:0]     tail_sum;
   logic [SLOT_W-1:0]   tail_idx;
   logic [SLOT_W-1:0]   head_dec;
   logic [SLOT_W-1:0]   head_inc;
   logic [SLOT_W-1:0]   wr_idx;
   logic [SLOT_W-1:0]   new_head;
   logic                do_add;
   logic                do_take;

   // class index reduced onto the configured class count
   always_comb begin
      cls_sel = '0;
      for (int i = 0; i < (1 << CLASS_IN_W); i++) begin
         if (req_data.class_index == CLASS_IN_W'(i)) begin
            cls_sel = CLS_W'(i % CLASSES);
         end
      end
   end

   // class state as read, unwritten classes read as empty
   assign head  = meta_ok_ff ? meta_rd_ff[META_W-1:CNT_W] : '0;
   assign cnt   = meta_ok_ff ? meta_rd_ff[CNT_W-1:0] : '0;

   // effective limit and occupancy checks
   assign limit = (LIM_W'(cap_ff) > LIM_W'(SLOTS)) ? LIM_W'(SLOTS) : LIM_W'(cap_ff);
   assign full  = (LIM_W'(cnt) >= limit);
   assign empty = (cnt == '0);

   // circular index arithmetic
   assign tail_sum = {1'b0, head} + (SLOT_W+1)'(cnt);
   assign tail_idx = (tail_sum >= (SLOT_W+1)'(SLOTS)) ?
                     SLOT_W'(tail_sum - (SLOT_W+1)'(SLOTS)) : SLOT_W'(tail_sum);
   assign head_dec = (head == '0) ? SLOT_W'(SLOTS - 1) : head - SLOT_W'(1);
   assign head_inc = (head == SLOT_W'(SLOTS - 1)) ? '0 : head + SLOT_W'(1);
   assign wr_idx   = req_ff.urgent ? head_dec : tail_idx;
   assign new_head = req_ff.urgent ? head_dec : head;

   assign do_add  = cmd.commit && (req_ff.func == FUNC_ADD) && !full;
   assign do_take = cmd.commit && (req_ff.func == FUNC_TAKE) && !empty;

   assign sts.is_take = (req_ff.func == FUNC_TAKE);
   assign sts.blocked = (req_ff.func == FUNC_TAKE) ? empty : full;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
         cls_ff <= cls_sel;
      end
   end

   // class pointer memory
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         meta_rd_ff <= meta_mem[cls_sel];
      end
      if (do_add) begin
         meta_mem[cls_ff] <= {new_head, cnt + CNT_W'(1)};
      end else if (do_take) begin
         meta_mem[cls_ff] <= {head_inc, cnt - CNT_W'(1)};
      end
   end

   // class valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         class_valid_ff <= '0;
         meta_ok_ff     <= 1'b0;
      end else begin
         if (cmd.capture) begin
            meta_ok_ff <= class_valid_ff[cls_sel];
         end
         if (do_add || do_take) begin
            class_valid_ff[cls_ff] <= 1'b1;
         end
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (do_add) begin
         slot_mem[cls_ff][wr_idx] <= TAG_BITS'(req_ff.item_tag);
      end
      if (do_take) begin
         slot_rd_ff <= slot_mem[cls_ff][head];
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.commit && !do_take) || cmd.finish_take;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.finish_take) begin
         rsp_data_ff.status    <= ST_TAKEN;
         rsp_data_ff.taken_tag <= TAG_IN_W'(slot_rd_ff);
      end else if (cmd.commit) begin
         rsp_data_ff.taken_tag <= '0;
         if (req_ff.func == FUNC_TAKE) begin
            rsp_data_ff.status <= ST_EMPTY;
         end else if (full) begin
            rsp_data_ff.status <= ST_FULL;
         end else begin
            rsp_data_ff.status <= ST_ADDED;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a class never holds more than the slot count
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (cnt <= CNT_W'(SLOTS)))
      else $error("class count beyond slot count");

   // a response follows every commit that is not a successful take
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !do_take) |=> rsp_valid)
      else $error("commit without response");

   // a successful take responds with ST_TAKEN after the slot readout state
   a_take_rsp: assert property (@(posedge clock) disable iff (reset)
      do_take |=> ##1 (rsp_valid && rsp_data.status == ST_TAKEN))
      else $error("take response missing");

endmodule

// File: design/per_class_bounded_deque.sv
// Per-class bounded deque: one small circular deque of tags for each class. A request is
// taken when start is high and busy is low; busy then stays high until the request has
// finished. Each request passes through a capture step, which registers the class head and
// count read from the pointer memory, and a commit step; a take that finds an item adds a
// slot readout step for the registered read of the slot memory. Exactly one response comes
// back per request, on rsp_data for a single cycle marked by rsp_valid, and it must be
// taken then: the block cannot hold it. The response shows in the cycle in which busy is
// already low, so the next request may start alongside it. No clearing pass follows reset;
// classes come out of reset empty. csr_wdata written with csr_we sets the capacity limit
// and should only be written while busy is low.
// top level; depends on pcbd_pkg, pcbd_ctrl and pcbd_datapath
module per_class_bounded_deque #(
   parameter int CLASSES  = 32,
   parameter int SLOTS    = 8,
   parameter int TAG_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  pcbd_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output pcbd_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [pcbd_pkg::CAP_W-1:0] csr_wdata
);
   import pcbd_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // request sequencing
   pcbd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // class state, slots and response
   pcbd_datapath #(
      .CLASSES  (CLASSES),
      .SLOTS    (SLOTS),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // responses never come in two adjacent cycles
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back responses");

   // an accepted request makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   // a response only appears once the request is done
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // taken tag is zero unless an item was taken
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_TAKEN) |-> (rsp_data.taken_tag == '0))
      else $error("nonzero tag on non-take response");

endmodule

// File: verif/testbench.sv
// self-checking testbench for the per-class bounded deque
// drives add and take requests, predicts each response and compares it field by field
// depends on pcbd_pkg and per_class_bounded_deque
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pcbd_pkg::*;

   localparam int CLASS_COUNT = 32;
   localparam int SLOT_COUNT  = 8;
   localparam int CYCLE_LIMIT = 100000;
   localparam int SETTLE      = 4;
   localparam int RING_DEPTH  = 8;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_data  = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [CAP_W-1:0]    csr_wdata = '0;

   // shadow copy of the deques and the capacity register
   logic [TAG_IN_W-1:0] shadow_tags [CLASS_COUNT][SLOT_COUNT];
   logic [2:0]          shadow_head [CLASS_COUNT];
   logic [3:0]          shadow_count [CLASS_COUNT];
   logic [CAP_W-1:0]    shadow_cap;

   // expected responses in request order
   rsp_type             outcome_ring [RING_DEPTH];
   int                  ring_wr_ptr = 0;
   int                  ring_rd_ptr = 0;
   int                  mismatch_count = 0;
   int                  cycle_count    = 0;
   int                  sender_idle_pct = 0;
   logic [4:0]          hot_class [4];
   int                  hot_width = 1;

   per_class_bounded_deque u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // expected response of one request, updating the shadow deques
   function automatic rsp_type deque_outcome(input req_type r);
      logic [4:0] cls;
      logic [2:0] head;
      logic [2:0] slot;
      logic [3:0] cnt;
      logic [3:0] lim;
      rsp_type    o;
      cls  = r.class_index;
      head = shadow_head[cls];
      cnt  = shadow_count[cls];
      lim  = (shadow_cap > 4'd8) ? 4'd8 : shadow_cap;
      o    = '0;
      if (r.func == FUNC_ADD) begin
         if (cnt >= lim) begin
            o.status = ST_FULL;
         end else begin
            if (r.urgent) begin
               head = head - 3'd1;
               shadow_tags[cls][head] = r.item_tag;
               shadow_head[cls] = head;
            end else begin
               slot = head + cnt[2:0];
               shadow_tags[cls][slot] = r.item_tag;
            end
            shadow_count[cls] = cnt + 4'd1;
            o.status = ST_ADDED;
         end
      end else begin
         if (cnt == 4'd0) begin
            o.status = ST_EMPTY;
         end else begin
            o.status    = ST_TAKEN;
            o.taken_tag = shadow_tags[cls][head];
            shadow_head[cls]  = head + 3'd1;
            shadow_count[cls] = cnt - 4'd1;
         end
      end
      return o;
   endfunction

   function automatic req_type make_request(input logic func, input int cls,
                                            input logic urgent, input int tag);
      req_type r;
      r.func        = func;
      r.class_index = cls[4:0];
      r.urgent      = urgent;
      r.item_tag    = tag[15:0];
      return r;
   endfunction

   // random request, mostly aimed at the current hot classes
   function automatic req_type random_request(input int add_pct);
      req_type r;
      r.func = ($urandom_range(99) < add_pct) ? FUNC_ADD : FUNC_TAKE;
      if ($urandom_range(9) < 8)
         r.class_index = hot_class[$urandom_range(hot_width - 1)];
      else
         r.class_index = 5'($urandom_range(CLASS_COUNT - 1));
      r.urgent   = 1'($urandom_range(1));
      r.item_tag = 16'($urandom_range(16'hFFFF));
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [17:0] want,
                                input logic [17:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %0d at cycle %0d: %s expected %h got %h",
                  mismatch_count, cycle_count, what, want, got);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (ring_wr_ptr == ring_rd_ptr) begin
            note_mismatch("unexpected response", '0, rsp_data);
         end else begin
            want = outcome_ring[ring_rd_ptr % RING_DEPTH];
            ring_rd_ptr++;
            if (rsp_data.status != want.status)
               note_mismatch("status", 18'(want.status), 18'(rsp_data.status));
            if (rsp_data.taken_tag != want.taken_tag)
               note_mismatch("taken_tag", 18'(want.taken_tag), 18'(rsp_data.taken_tag));
         end
      end
   end

   // one request, with idle cycles before it at the current idle rate
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      outcome_ring[ring_wr_ptr % RING_DEPTH] = deque_outcome(r);
      ring_wr_ptr++;
   endtask

   // stop sending and wait until every response is back
   task automatic drain_responses();
      start <= 1'b0;
      while (ring_wr_ptr != ring_rd_ptr) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      shadow_cap = value;
      csr_we    <= 1'b0;
   endtask

   // front insert wraps the head, back append and ordered takes
   task automatic test_order_and_urgent();
      send_request(make_request(FUNC_ADD, 0, 1'b0, 16'hFFFF));
      send_request(make_request(FUNC_ADD, 0, 1'b1, 16'h0000));
      send_request(make_request(FUNC_ADD, 0, 1'b0, 16'h5A5A));
      repeat (4) send_request(make_request(FUNC_TAKE, 0, 1'b0, 0));
      drain_responses();
   endtask

   // take on empty ignores urgent and tag, adds stop at the reset limit
   task automatic test_full_and_empty();
      send_request(make_request(FUNC_TAKE, 31, 1'b1, 16'hFFFF));
      for (int i = 0; i < 6; i++)
         send_request(make_request(FUNC_ADD, 31, 1'(i), 16'h8000 + i));
      send_request(make_request(FUNC_TAKE, 31, 1'b0, 0));
      drain_responses();
   endtask

   // zero limit rejects every add but takes still work
   task automatic test_zero_limit();
      write_capacity(4'd0);
      send_request(make_request(FUNC_ADD, 3, 1'b0, 16'h1234));
      send_request(make_request(FUNC_ADD, 31, 1'b1, 16'hABCD));
      send_request(make_request(FUNC_TAKE, 31, 1'b0, 0));
      drain_responses();
   endtask

   // random traffic in bursts over a few hot classes, with a full pause midway
   task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int idle_pct,
                                      input int count);
      int add_pct;
      add_pct = 50;
      write_capacity(cap);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) begin
            hot_width = $urandom_range(1, 4);
            foreach (hot_class[k]) hot_class[k] = 5'($urandom_range(CLASS_COUNT - 1));
            case ($urandom_range(2))
               0: begin
                  add_pct = 30;
               end
               1: begin
                  add_pct = 55;
               end
               default: begin
                  add_pct = 80;
               end
            endcase
         end
         if (i == count / 2) drain_responses();
         send_request(random_request(add_pct));
      end
      drain_responses();
      sender_idle_pct = 0;
   endtask

   initial begin
      foreach (shadow_head[c]) begin
         shadow_head[c]  = '0;
         shadow_count[c] = '0;
      end
      foreach (shadow_tags[c, s]) shadow_tags[c][s] = '0;
      shadow_cap = CAP_RESET;
      foreach (hot_class[k]) hot_class[k] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_order_and_urgent();
      test_full_and_empty();
      test_zero_limit();
      test_random_traffic(4'd8, 0, 160);
      test_random_traffic(4'd15, 83, 160);
      test_random_traffic(4'd1, 23, 160);
      test_random_traffic(4'd9, 0, 160);
      test_random_traffic(4'd3, 83, 160);

      drain_responses();
      if (mismatch_count == 0 && ring_wr_ptr == ring_rd_ptr)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
